FILE: hw/rtl/tsc_deadline_timer_core_macros.svh
// Assertion macros shared by the deadline timer RTL.
`ifndef TSC_DEADLINE_TIMER_CORE_MACROS_SVH
`define TSC_DEADLINE_TIMER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TSC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deadline timer assertion failed");
`define TSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deadline timer assertion failed");
`else
`define TSC_ASSERT_IMPL(lbl, ante, cons)
`define TSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/tsc_pkg.sv
// Shared types, codes and constants of the deadline timer.
package tsc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR = 2'd2;

  localparam logic [31:0] FREQ_RESET   = 32'd2000000;
  localparam logic [4:0]  SHIFT_RESET  = 5'd5;
  localparam logic [7:0]  VECTOR_RESET = 8'd236;

  localparam logic [1:0] KIND_DEADLINE = 2'd0;
  localparam logic [1:0] KIND_TICK     = 2'd1;
  localparam logic [1:0] KIND_HALT     = 2'd2;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_ARMED    = 3'd1;
  localparam logic [2:0] ACT_QUEUED   = 3'd2;
  localparam logic [2:0] ACT_INJECTED = 3'd3;
  localparam logic [2:0] ACT_NOHALT   = 3'd4;
  localparam logic [2:0] ACT_YIELD    = 3'd5;

  typedef struct packed {
    logic [31:0] freq_khz;
    logic [4:0]  shift;
    logic [7:0]  vector;
  } cfg_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  vector;
    logic [31:0] remaining;
    logic [63:0] scaled;
    logic        need_div;
  } op_t;

endpackage

FILE: hw/rtl/tsc_if.sv
// Input and output channel interfaces of the deadline timer.
interface tsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] deadline;
  logic [63:0] current_tsc;
  logic        interrupts_enabled;

  modport source (output valid, kind, deadline, current_tsc, interrupts_enabled,
                  input ready);
  modport sink   (input valid, kind, deadline, current_tsc, interrupts_enabled,
                  output ready);
endinterface

interface tsc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  vector;
  logic [63:0] yield_us;
  logic [31:0] remaining_count;

  modport source (output valid, action, vector, yield_us, remaining_count,
                  input ready);
  modport sink   (input valid, action, vector, yield_us, remaining_count,
                  output ready);
endinterface

FILE: hw/rtl/tsc_deadline_timer_core.sv
// Top level of the deadline timer: configuration registers, front end, queue, back end.
//
//   Channel   Dir  Handshake          Beat payload
//   in_i      in   valid/ready        kind, deadline, current_tsc, interrupts_enabled
//   out_o     out  valid/ready        action, vector, yield_us, remaining_count
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// Items other than a yielding halt go from the queue straight into the output register.
// A halt that yields holds the back end while it is taken from the queue, scaled, run
// through the 64 steps of the one-bit-per-cycle divider and loaded into the output
// register.
// The two-entry queue takes two more beats during that time before the input stalls.
// Reset clears the countdown, the armed flag, the queue and the output valid.
`include "tsc_deadline_timer_core_macros.svh"

module tsc_deadline_timer_core #(
  parameter int COUNT_WIDTH = tsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  tsc_in_if.sink                           in_i,
  tsc_out_if.source                        out_o
);

  tsc_pkg::cfg_t cfg_q, cfg_d;
  tsc_pkg::op_t  push_entry;
  tsc_pkg::op_t  head_entry;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  logic          irq_free_beat;
  logic          yield_free_beat;
  logic          armed_beat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsc_pkg::CFG_FREQ:   cfg_d.freq_khz = cfg_wdata_i;
        tsc_pkg::CFG_SHIFT:  cfg_d.shift    = cfg_wdata_i[4:0];
        tsc_pkg::CFG_VECTOR: cfg_d.vector   = cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.freq_khz <= tsc_pkg::FREQ_RESET;
      cfg_q.shift    <= tsc_pkg::SHIFT_RESET;
      cfg_q.vector   <= tsc_pkg::VECTOR_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tsc_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .shift_i  (cfg_q.shift),
    .vector_i (cfg_q.vector),
    .full_i   (full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  tsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (head_entry)
  );

  tsc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_entry),
    .empty_i    (empty),
    .pop_o      (pop),
    .freq_khz_i (cfg_q.freq_khz),
    .out_o      (out_o)
  );

  assign irq_free_beat   = out_o.valid && (out_o.action == tsc_pkg::ACT_NONE ||
                                           out_o.action == tsc_pkg::ACT_ARMED ||
                                           out_o.action == tsc_pkg::ACT_NOHALT);
  assign yield_free_beat = out_o.valid && (out_o.action != tsc_pkg::ACT_YIELD);
  assign armed_beat      = out_o.valid && (out_o.action == tsc_pkg::ACT_ARMED);

  // Only queued, injected and yielding results carry a vector.
  `TSC_ASSERT_IMPL(a_vector_only_with_irq, irq_free_beat, out_o.vector == 8'd0)
  // Yield time is reported only for a yielding halt.
  `TSC_ASSERT_IMPL(a_yield_only_on_yield, yield_free_beat, out_o.yield_us == 64'd0)
  // An armed counter never starts at zero.
  `TSC_ASSERT_IMPL(a_armed_nonzero, armed_beat, out_o.remaining_count != 32'd0)
  // A full queue never takes another beat.
  `TSC_ASSERT_NEXT(a_no_accept_when_full, full && !pop, !(in_i.valid && in_i.ready) || !full)

endmodule

FILE: hw/rtl/tsc_queue.sv
// Short queue of classified items between the front and back ends.
module tsc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tsc_pkg::op_t  entry_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tsc_pkg::op_t  entry_o
);

  localparam int CntW = $clog2(tsc_pkg::QUEUE_DEPTH + 1);

  tsc_pkg::op_t                 mem_q [tsc_pkg::QUEUE_DEPTH];
  logic [tsc_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [tsc_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]              cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(tsc_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == tsc_pkg::QPTR_W'(tsc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == tsc_pkg::QPTR_W'(tsc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: hw/rtl/tsc_front.sv
// Front end: accepts items, updates the countdown and classifies each item.
module tsc_front #(
  parameter int COUNT_WIDTH = tsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tsc_in_if.sink        in_i,
  input  logic [4:0]    shift_i,
  input  logic [7:0]    vector_i,
  input  logic          full_i,
  output logic          push_o,
  output tsc_pkg::op_t  entry_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   armed_q, armed_d;
  logic [63:0]            diff;
  logic [63:0]            shifted;
  logic                   over;
  logic [COUNT_WIDTH-1:0] load_val;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  assign diff    = in_i.deadline - in_i.current_tsc;
  assign shifted = diff >> shift_i;
  // Any bit above the counter width means the load saturates.
  assign over    = (shifted >> COUNT_WIDTH) != 64'd0;

  always_comb begin
    if (over) begin
      load_val = '1;
    end else if (shifted == 64'd0) begin
      load_val = COUNT_WIDTH'(1);
    end else begin
      load_val = shifted[COUNT_WIDTH-1:0];
    end
  end

  always_comb begin
    count_d          = count_q;
    armed_d          = armed_q;
    entry_o.action   = tsc_pkg::ACT_NONE;
    entry_o.vector   = 8'd0;
    entry_o.need_div = 1'b0;
    entry_o.scaled   = 64'(count_q) << shift_i;
    unique case (in_i.kind)
      tsc_pkg::KIND_DEADLINE: begin
        if (in_i.deadline > in_i.current_tsc) begin
          count_d        = load_val;
          armed_d        = 1'b1;
          entry_o.action = tsc_pkg::ACT_ARMED;
        end else begin
          entry_o.action = tsc_pkg::ACT_QUEUED;
          entry_o.vector = vector_i;
        end
      end
      tsc_pkg::KIND_TICK: begin
        if (armed_q) begin
          if (count_q <= COUNT_WIDTH'(1)) begin
            count_d        = '0;
            armed_d        = 1'b0;
            entry_o.action = tsc_pkg::ACT_QUEUED;
            entry_o.vector = vector_i;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
      end
      tsc_pkg::KIND_HALT: begin
        if (!in_i.interrupts_enabled) begin
          entry_o.action = tsc_pkg::ACT_NOHALT;
        end else begin
          armed_d        = 1'b0;
          entry_o.vector = vector_i;
          if (count_q != '0) begin
            entry_o.action   = tsc_pkg::ACT_YIELD;
            entry_o.need_div = 1'b1;
          end else begin
            entry_o.action = tsc_pkg::ACT_INJECTED;
          end
        end
      end
      default: begin
      end
    endcase
    entry_o.remaining = 32'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      armed_q <= 1'b0;
    end else if (push_o) begin
      count_q <= count_d;
      armed_q <= armed_d;
    end
  end

endmodule

FILE: hw/rtl/tsc_back.sv
// Back end: yield-time scaling, iterative divider and the output register.
module tsc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tsc_pkg::op_t  head_i,
  input  logic          empty_i,
  output logic          pop_o,
  input  logic [31:0]   freq_khz_i,
  tsc_out_if.source     out_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam int DivSteps = 64;
  localparam int StepW    = $clog2(DivSteps);

  logic [1:0]        state_q, state_d;
  tsc_pkg::op_t      work_q, work_d;
  logic [63:0]       dvd_q, dvd_d;
  logic [31:0]       rem_q, rem_d;
  logic [StepW-1:0]  step_q, step_d;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        out_action_q, out_action_d;
  logic [7:0]        out_vector_q, out_vector_d;
  logic [63:0]       out_yield_q, out_yield_d;
  logic [31:0]       out_rem_q, out_rem_d;

  logic              out_free;
  logic              load_out;
  logic [32:0]       trial;
  logic [33:0]       trial_diff;
  logic              trial_ge;

  assign out_free = !out_valid_q || out_o.ready;

  // One quotient bit per cycle, restoring form. A zero divisor yields all ones.
  assign trial      = {rem_q, dvd_q[63]};
  assign trial_diff = {1'b0, trial} - {2'b00, freq_khz_i};
  assign trial_ge   = !trial_diff[33];

  always_comb begin
    state_d      = state_q;
    work_d       = work_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    step_d       = step_q;
    pop_o        = 1'b0;
    load_out     = 1'b0;
    out_action_d = out_action_q;
    out_vector_d = out_vector_q;
    out_yield_d  = out_yield_q;
    out_rem_d    = out_rem_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          if (head_i.need_div) begin
            work_d  = head_i;
            state_d = ST_SCALE;
          end else begin
            load_out     = 1'b1;
            out_action_d = head_i.action;
            out_vector_d = head_i.vector;
            out_yield_d  = 64'd0;
            out_rem_d    = head_i.remaining;
          end
        end
      end
      ST_SCALE: begin
        // Times 1000 as 1024 - 16 - 8, modulo 2^64.
        dvd_d   = (work_q.scaled << 10) - (work_q.scaled << 4) - (work_q.scaled << 3);
        rem_d   = 32'd0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        dvd_d  = {dvd_q[62:0], trial_ge};
        rem_d  = trial_ge ? trial_diff[31:0] : trial[31:0];
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_action_d = work_q.action;
          out_vector_d = work_q.vector;
          out_yield_d  = dvd_q;
          out_rem_d    = work_q.remaining;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q       <= work_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    step_q       <= step_d;
    out_action_q <= out_action_d;
    out_vector_q <= out_vector_d;
    out_yield_q  <= out_yield_d;
    out_rem_q    <= out_rem_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.action          = out_action_q;
  assign out_o.vector          = out_vector_q;
  assign out_o.yield_us        = out_yield_q;
  assign out_o.remaining_count = out_rem_q;

endmodule
